// ===== rtl/ackdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ackdf_pkg
// Shared types, constants and AES helper functions for the key derivation core.
// ----------------------------------------------------------------------------
package ackdf_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_W     = 8 * BLOCK_BYTES;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CNT_W       = 5;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE   = 3'd4;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;
    localparam logic [1:0] KEY_256 = 2'd2;

    typedef enum logic [1:0] {
        FUNC_BEGIN  = 2'd0,
        FUNC_ABSORB = 2'd1,
        FUNC_OUTPUT = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_INIT,
        ST_ROUND,
        ST_DONE,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic start;
        logic last;
    } rnd_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ===== rtl/ackdf_key_exp.sv =====
// ----------------------------------------------------------------------------
// ackdf_key_exp
// Round key store and sequential key schedule, one 32-bit word per cycle.
// ----------------------------------------------------------------------------
module ackdf_key_exp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [4*ackdf_pkg::CFG_DATA_W-1:0] key,
    input  logic [1:0]                      key_size,
    input  logic [3:0]                      rd_round,
    output logic [ackdf_pkg::BLOCK_W-1:0]   rd_key,
    output logic                            busy
);

    logic [ackdf_pkg::BLOCK_W-1:0] rk_mem [15];
    logic [31:0] win_reg [8];
    logic [5:0]  idx_reg, idx_next;
    logic        busy_reg, busy_next;
    logic [2:0]  ph_reg, ph_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic [31:0] wr_word;
    logic [5:0]  total;
    logic [3:0]  nk;
    logic        wr_en;
    logic [31:0] t;

    always_comb
    begin
        case (key_size)
            ackdf_pkg::KEY_128: nk = 4'd4;
            ackdf_pkg::KEY_192: nk = 4'd6;
            default:            nk = 4'd8;
        endcase
        total = 6'(4 * (nk + 7));
    end

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        ph_next   = ph_reg;
        rcon_next = rcon_reg;
        wr_en     = 1'b0;
        wr_word   = '0;
        t         = win_reg[0];
        if (start)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
            ph_next   = '0;
            rcon_next = 8'h01;
        end
        else if (busy_reg)
        begin
            wr_en = 1'b1;
            if ({1'b0, idx_reg} < {3'b0, nk})
            begin
                wr_word = idx_reg[0] ? key[(3 - idx_reg[2:1]) * 64 +: 32]
                                     : key[(3 - idx_reg[2:1]) * 64 + 32 +: 32];
            end
            else
            begin
                if (ph_reg == 3'd0)
                begin
                    t = ackdf_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                        ^ {rcon_reg, 24'h0};
                end
                else if (nk == 4'd8 && ph_reg == 3'd4)
                begin
                    t = ackdf_pkg::sub_word(win_reg[0]);
                end
                wr_word = win_reg[3'(nk - 4'd1)] ^ t;
            end
            if ({1'b0, idx_reg} >= {3'b0, nk})
            begin
                if ({1'b0, ph_reg} == nk - 4'd1)
                begin
                    ph_next = '0;
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
                if (ph_reg == 3'd0)
                begin
                    rcon_next = ackdf_pkg::xtime(rcon_reg);
                end
            end
            idx_next = idx_reg + 6'd1;
            if (idx_reg == total - 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            ph_reg   <= '0;
            rcon_reg <= 8'h01;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            ph_reg   <= ph_next;
            rcon_reg <= rcon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rk_mem[idx_reg[5:2]][(3 - int'(idx_reg[1:0])) * 32 +: 32] <= wr_word;
            for (int i = 7; i > 0; i--)
            begin
                win_reg[i] <= win_reg[i - 1];
            end
            win_reg[0] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key <= rk_mem[rd_round];
    end

    assign busy = busy_reg | start;

endmodule

// ===== rtl/ackdf_round.sv =====
// ----------------------------------------------------------------------------
// ackdf_round
// Shared AES round unit; state register updated once per cycle while step is high.
// ----------------------------------------------------------------------------
module ackdf_round
(
    input  logic                          clk,
    input  ackdf_pkg::rnd_ctl_t           ctl,
    input  logic [ackdf_pkg::BLOCK_W-1:0] blk_in,
    input  logic [ackdf_pkg::BLOCK_W-1:0] rkey,
    input  logic                          step,
    output logic [ackdf_pkg::BLOCK_W-1:0] state
);

    logic [ackdf_pkg::BLOCK_W-1:0] st_reg, st_next;
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = ackdf_pkg::sbox(st_reg[(15 - i) * 8 +: 8]);
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[4 * c + i] = s[4 * ((c + i) % 4) + i];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int i = 0; i < 4; i++)
            begin
                m[4*c+i] = ctl.last ? t[4*c+i]
                         : t[4*c+i] ^ all ^ ackdf_pkg::xtime(t[4*c+i] ^ t[4*c+(i+1)%4]);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            st_next[(15 - i) * 8 +: 8] = m[i];
        end
        st_next = st_next ^ rkey;
        if (ctl.start)
        begin
            st_next = blk_in ^ rkey;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            st_reg <= st_next;
        end
    end

    assign state = st_reg;

endmodule

// ===== rtl/aes_chain_then_counter_kdf_core.sv =====
// ----------------------------------------------------------------------------
// aes_chain_then_counter_kdf_core
// AES CBC-MAC absorb followed by counter-mode keystream output.
// ----------------------------------------------------------------------------
// A begin item, and an absorb item that does not close a block, is taken
// without leaving idle. An absorb item that closes a block, and every output
// item, passes through acceptance, key load and setup, then runs the shared AES
// round unit for 10, 12 or 14 rounds, each a round key read followed by a round,
// then hand-off; an output item holds longer while the previous keystream item
// still waits. A key register write restarts the key schedule, one 32-bit word
// per cycle; the input is held off while the schedule runs after the write.
// ----------------------------------------------------------------------------
module aes_chain_then_counter_kdf_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ackdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ackdf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,  // func, info_byte, out_bytes
    input  logic                               s_tlast,  // info_last
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [135:0]                       m_tdata   // stream_high, stream_low, valid_bytes
);

    localparam int BLOCK_BYTES = ackdf_pkg::BLOCK_BYTES;
    localparam int BW = 8 * BLOCK_BYTES;
    localparam int PW = $clog2(BLOCK_BYTES);

    logic [4*ackdf_pkg::CFG_DATA_W-1:0] key_reg;
    logic [1:0]      ksz_reg;
    logic            kstart_reg;
    logic            kbusy;
    logic [BW-1:0]   chain_reg, chain_next;
    logic [PW-1:0]   pos_reg, pos_next;
    ackdf_pkg::state_t st_reg, st_next;
    logic [3:0]      rnd_reg, rnd_next, nr;
    logic            outm_reg, outm_next;
    logic [ackdf_pkg::CNT_W-1:0] n_reg, n_next;
    logic [BW-1:0]   blk;
    logic [ackdf_pkg::BLOCK_W-1:0] rkey, aes_st;
    ackdf_pkg::rnd_ctl_t ctl;
    logic            step;
    logic [135:0]    out_reg, out_next;
    logic            mv_reg, mv_next;
    ackdf_pkg::func_t func;
    logic [7:0]      ibyte;
    logic [ackdf_pkg::CNT_W-1:0] req;
    logic [BW-1:0]   xored, mask;

    assign func  = ackdf_pkg::func_t'(s_tdata[1:0]);
    assign ibyte = s_tdata[9:2];
    assign req   = s_tdata[14:10];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            ksz_reg    <= ackdf_pkg::KEY_128;
            kstart_reg <= 1'b1;
        end
        else
        begin
            kstart_reg <= 1'b0;
            if (cfg_we && cfg_index <= ackdf_pkg::REG_KEY_SIZE)
            begin
                kstart_reg <= 1'b1;
                case (cfg_index)
                    ackdf_pkg::REG_KEY_WORD_0: key_reg[255:192] <= cfg_data;
                    ackdf_pkg::REG_KEY_WORD_1: key_reg[191:128] <= cfg_data;
                    ackdf_pkg::REG_KEY_WORD_2: key_reg[127:64]  <= cfg_data;
                    ackdf_pkg::REG_KEY_WORD_3: key_reg[63:0]    <= cfg_data;
                    default: ksz_reg <= (cfg_data[1:0] == 2'd3) ? ackdf_pkg::KEY_256
                                                                : cfg_data[1:0];
                endcase
            end
        end
    end

    always_comb
    begin
        case (ksz_reg)
            ackdf_pkg::KEY_128: nr = 4'd10;
            ackdf_pkg::KEY_192: nr = 4'd12;
            default:            nr = 4'd14;
        endcase
    end

    ackdf_key_exp u_key
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (kstart_reg),
        .key      (key_reg),
        .key_size (ksz_reg),
        .rd_round (rnd_reg),
        .rd_key   (rkey),
        .busy     (kbusy)
    );

    ackdf_round u_rnd
    (
        .clk    (clk),
        .ctl    (ctl),
        .blk_in (blk),
        .rkey   (rkey),
        .step   (step),
        .state  (aes_st)
    );

    assign blk = chain_reg;

    always_comb
    begin
        xored = chain_reg;
        xored[(BLOCK_BYTES - 1 - int'(pos_reg)) * 8 +: 8] =
            chain_reg[(BLOCK_BYTES - 1 - int'(pos_reg)) * 8 +: 8] ^ ibyte;
    end

    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            mask[(BLOCK_BYTES - 1 - i) * 8 +: 8] = (i < int'(n_reg)) ? 8'hff : 8'h00;
        end
    end

    assign s_tready = (st_reg == ackdf_pkg::ST_IDLE) && !kbusy;

    always_comb
    begin
        st_next    = st_reg;
        chain_next = chain_reg;
        pos_next   = pos_reg;
        rnd_next   = rnd_reg;
        outm_next  = outm_reg;
        n_next     = n_reg;
        out_next   = out_reg;
        mv_next    = mv_reg;
        ctl        = '0;
        step       = 1'b0;
        if (m_tvalid && m_tready)
        begin
            mv_next = 1'b0;
        end
        case (st_reg)
            ackdf_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    case (func)
                        ackdf_pkg::FUNC_BEGIN:
                        begin
                            chain_next = '0;
                            pos_next   = '0;
                        end
                        ackdf_pkg::FUNC_ABSORB:
                        begin
                            chain_next = xored;
                            pos_next   = pos_reg + PW'(1);
                            if (pos_reg == PW'(BLOCK_BYTES - 1) || s_tlast)
                            begin
                                pos_next  = '0;
                                outm_next = 1'b0;
                                rnd_next  = '0;
                                st_next   = ackdf_pkg::ST_KEY;
                            end
                        end
                        ackdf_pkg::FUNC_OUTPUT:
                        begin
                            chain_next = chain_reg + BW'(1);
                            n_next     = (req == '0) ? 5'd1 : (req > 5'd16) ? 5'd16 : req;
                            outm_next  = 1'b1;
                            rnd_next   = '0;
                            st_next    = ackdf_pkg::ST_KEY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ackdf_pkg::ST_KEY:
            begin
                st_next = ackdf_pkg::ST_INIT;
            end
            ackdf_pkg::ST_INIT:
            begin
                ctl.start = 1'b1;
                step      = 1'b1;
                rnd_next  = 4'd1;
                st_next   = ackdf_pkg::ST_ROUND;
            end
            ackdf_pkg::ST_ROUND:
            begin
                st_next = ackdf_pkg::ST_DONE;
            end
            ackdf_pkg::ST_DONE:
            begin
                ctl.last = (rnd_reg == nr);
                step     = 1'b1;
                if (rnd_reg == nr)
                begin
                    st_next = ackdf_pkg::ST_HOLD;
                end
                else
                begin
                    rnd_next = rnd_reg + 4'd1;
                    st_next  = ackdf_pkg::ST_ROUND;
                end
            end
            ackdf_pkg::ST_HOLD:
            begin
                if (!outm_reg)
                begin
                    chain_next = aes_st;
                    st_next    = ackdf_pkg::ST_IDLE;
                end
                else if (!mv_next)
                begin
                    out_next = {3'b0, n_reg, aes_st[63:0] & mask[63:0],
                                aes_st[127:64] & mask[127:64]};
                    mv_next  = 1'b1;
                    st_next  = ackdf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = ackdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ackdf_pkg::ST_IDLE;
            chain_reg <= '0;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            outm_reg  <= 1'b0;
            n_reg     <= 5'd1;
            mv_reg    <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            chain_reg <= chain_next;
            pos_reg   <= pos_next;
            rnd_reg   <= rnd_next;
            outm_reg  <= outm_next;
            n_reg     <= n_next;
            mv_reg    <= mv_next;
            out_reg   <= out_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== tb/tb_aes_chain_then_counter_kdf_core.sv =====
// ----------------------------------------------------------------------------
// tb_aes_chain_then_counter_kdf_core
// Self-checking bench for the AES chain absorb and counter keystream core.
// A behavioral AES predictor follows every accepted item; keystream blocks
// are compared field by field against a queue of predicted blocks while
// both stream sides idle at random and the output side holds off at times.
// ----------------------------------------------------------------------------
module tb_aes_chain_then_counter_kdf_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  cnt;
    } ks_block_t;

    typedef struct {
        ackdf_pkg::func_t fn;
        logic [7:0] info;
        logic       last;
        logic [4:0] nbytes;
        logic       has_fixed;
        ks_block_t  fixed;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [ackdf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ackdf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;   // func[1:0], info_byte[9:2], out_bytes[14:10], pad
    logic s_tlast = 1'b0;        // info_last
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [135:0] m_tdata;       // stream_high[63:0], stream_low[127:64], valid_bytes[132:128]

    always #1 clk = ~clk;

    aes_chain_then_counter_kdf_core dut (.*);

    logic [63:0] key_regs [4];
    logic [1:0] key_len;
    logic [7:0] chain [16];
    int unsigned chain_pos;
    logic [31:0] rk [60];
    int unsigned nrounds;

    ks_block_t expected_blocks [$];
    ks_block_t fixed_blocks [$];
    logic [0:0] fixed_mask [$];
    int errors = 0;
    bit holdoff = 1'b0;
    bit calm = 1'b0;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        int k;
        r = '0;
        x = a;
        for (k = 0; k < 8; k++)
        begin
            if (b[k]) r ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] sb(input logic [7:0] a);
        logic [7:0] inv_res;
        logic [7:0] x;
        logic [7:0] p;
        logic [7:0] r;
        logic [7:0] b;
        int k;
        int e;
        // inverse in GF(2^8) by a^254
        r = 8'h01;
        b = a;
        e = 254;
        for (k = 0; k < 8; k++)
        begin
            if (e[k]) r = gmul(r, b);
            b = gmul(b, b);
        end
        inv_res = (a == 8'h00) ? 8'h00 : r;
        x = inv_res;
        p = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]};
        return p ^ 8'h63;
    endfunction

    function automatic logic [31:0] sw(input logic [31:0] w);
        return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
    endfunction

    function automatic void build_schedule();
        int unsigned nk;
        int unsigned i;
        logic [31:0] t;
        logic [7:0] rc;
        nk = (key_len == ackdf_pkg::KEY_128) ? 4 : (key_len == ackdf_pkg::KEY_192) ? 6 : 8;
        nrounds = nk + 6;
        for (i = 0; i < nk; i++)
            rk[i] = i[0] ? key_regs[i/2][31:0] : key_regs[i/2][63:32];
        rc = 8'h01;
        for (i = nk; i < 4 * (nrounds + 1); i++)
        begin
            t = rk[i-1];
            if (i % nk == 0)
            begin
                t = sw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul(rc, 8'h02);
            end
            else if (nk > 6 && i % nk == 4)
                t = sw(t);
            rk[i] = rk[i-nk] ^ t;
        end
    endfunction

    function automatic void add_rk(ref logic [7:0] s [16], input int unsigned r);
        int c;
        for (c = 0; c < 4; c++)
        begin
            s[4*c]   ^= rk[4*r+c][31:24];
            s[4*c+1] ^= rk[4*r+c][23:16];
            s[4*c+2] ^= rk[4*r+c][15:8];
            s[4*c+3] ^= rk[4*r+c][7:0];
        end
    endfunction

    function automatic void aes_encrypt(input logic [7:0] pt [16], output logic [7:0] ct [16]);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        int unsigned r;
        int c;
        int i;
        s = pt;
        add_rk(s, 0);
        for (r = 1; r <= nrounds; r++)
        begin
            for (i = 0; i < 16; i++) s[i] = sb(s[i]);
            for (c = 0; c < 4; c++)
                for (i = 0; i < 4; i++)
                    t[4*c+i] = s[4*((c+i)%4)+i];
            if (r != nrounds)
            begin
                for (c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    s[4*c]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
                    s[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
                    s[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
                    s[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
                end
            end
            else
                s = t;
            add_rk(s, r);
        end
        ct = s;
    endfunction

    function automatic void kdf_reset();
        int i;
        for (i = 0; i < 4; i++) key_regs[i] = '0;
        key_len = ackdf_pkg::KEY_128;
        for (i = 0; i < 16; i++) chain[i] = '0;
        chain_pos = 0;
        build_schedule();
    endfunction

    function automatic void kdf_write_reg(input logic [ackdf_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [63:0] val);
        if (idx <= ackdf_pkg::REG_KEY_WORD_3)
            key_regs[idx[1:0]] = val;
        else if (idx == ackdf_pkg::REG_KEY_SIZE)
            key_len = (val[1:0] == 2'd3) ? ackdf_pkg::KEY_256 : val[1:0];
        else
            return;
        build_schedule();
    endfunction

    // returns 1 and fills blk when the item yields a keystream block
    function automatic bit kdf_step(input ackdf_pkg::func_t fn, input logic [7:0] info,
                                    input logic last, input logic [4:0] nb,
                                    output ks_block_t blk);
        logic [7:0] ks [16];
        int unsigned n;
        int z;
        int i;
        blk = '0;
        case (fn)
            ackdf_pkg::FUNC_BEGIN:
            begin
                for (i = 0; i < 16; i++) chain[i] = '0;
                chain_pos = 0;
                return 1'b0;
            end
            ackdf_pkg::FUNC_ABSORB:
            begin
                chain[chain_pos] ^= info;
                chain_pos = (chain_pos + 1) % 16;
                if (chain_pos == 0 || last)
                begin
                    aes_encrypt(chain, chain);
                    chain_pos = 0;
                end
                return 1'b0;
            end
            ackdf_pkg::FUNC_OUTPUT:
            begin
                n = (nb == 0) ? 1 : (nb > 16) ? 16 : nb;
                for (z = 15; z >= 0; z--)
                begin
                    chain[z] = chain[z] + 8'd1;
                    if (chain[z] != 8'd0) break;
                end
                aes_encrypt(chain, ks);
                for (i = 0; i < 16; i++)
                    if (i < n)
                    begin
                        if (i < 8) blk.hi[63-8*i -: 8] = ks[i];
                        else blk.lo[63-8*(i-8) -: 8] = ks[i];
                    end
                blk.cnt = n[4:0];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic push_item(input ackdf_pkg::func_t fn, input logic [7:0] info,
                             input logic last, input logic [4:0] nb,
                             input bit has_fixed, input ks_block_t fx);
        ks_block_t blk;
        while (!calm && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, nb, info, fn};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (kdf_step(fn, info, last, nb, blk))
        begin
            expected_blocks.push_back(blk);
            fixed_mask.push_back(has_fixed);
            fixed_blocks.push_back(fx);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [ackdf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        s_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        kdf_write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_run(input int count);
        int k;
        int j;
        int len;
        int nout;
        k = 0;
        while (k < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                push_item(ackdf_pkg::func_t'($urandom_range(3)), 8'($urandom), 1'($urandom),
                          5'($urandom), 1'b0, '0);
                k++;
            end
            else
            begin
                len = $urandom_range(40);
                nout = $urandom_range(1, 4);
                push_item(ackdf_pkg::FUNC_BEGIN, 8'($urandom), 1'($urandom), 5'($urandom),
                          1'b0, '0);
                for (j = 0; j < len; j++)
                    push_item(ackdf_pkg::FUNC_ABSORB, 8'($urandom), ($urandom_range(9) == 0),
                              5'($urandom), 1'b0, '0);
                repeat (nout)
                    push_item(ackdf_pkg::FUNC_OUTPUT, 8'($urandom), 1'($urandom),
                              ($urandom_range(9) == 0) ? 5'($urandom)
                                                       : 5'($urandom_range(1, 16)),
                              1'b0, '0);
                k += len + 1 + nout;
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (holdoff)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= 17);
    end

    always @(posedge clk)
    begin
        ks_block_t got;
        ks_block_t want;
        ks_block_t fx;
        logic [0:0] has_fx;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{hi: m_tdata[63:0], lo: m_tdata[127:64], cnt: m_tdata[132:128]};
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: unexpected block hi=%h lo=%h cnt=%0d", $time,
                         got.hi, got.lo, got.cnt);
                errors++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                has_fx = fixed_mask.pop_front();
                fx = fixed_blocks.pop_front();
                if (has_fx && fx != want)
                begin
                    $display("%0t: predictor expected %h actual %h", $time, fx, want);
                    errors++;
                end
                if (got.hi !== want.hi)
                begin
                    $display("%0t: stream_high expected %h actual %h", $time, want.hi, got.hi);
                    errors++;
                end
                if (got.lo !== want.lo)
                begin
                    $display("%0t: stream_low expected %h actual %h", $time, want.lo, got.lo);
                    errors++;
                end
                if (got.cnt !== want.cnt)
                begin
                    $display("%0t: valid_bytes expected %0d actual %0d", $time,
                             want.cnt, got.cnt);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t r;
        int i;
        int p;
        kdf_reset();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (80) @(negedge clk);

        // zero key, zero chain: counter 1 block, known AES-128 vector for the all-zero key
        // is not used; the first rows are checked by the predictor alone
        rows.push_back('{ackdf_pkg::FUNC_OUTPUT, 8'h00, 1'b0, 5'd16, 1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_OUTPUT, 8'hff, 1'b1, 5'd0,  1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_OUTPUT, 8'h00, 1'b0, 5'd31, 1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_OUTPUT, 8'h00, 1'b0, 5'd17, 1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_NONE,   8'hff, 1'b1, 5'd31, 1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_BEGIN,  8'hff, 1'b1, 5'd31, 1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_ABSORB, 8'hff, 1'b0, 5'd1,  1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_ABSORB, 8'h00, 1'b0, 5'd1,  1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_OUTPUT, 8'h00, 1'b0, 5'd1,  1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_ABSORB, 8'h5a, 1'b1, 5'd0,  1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_OUTPUT, 8'h00, 1'b0, 5'd8,  1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_BEGIN,  8'h00, 1'b0, 5'd0,  1'b0, '0});
        for (i = 0; i < 15; i++)
            rows.push_back('{ackdf_pkg::FUNC_ABSORB, 8'(i * 17), (i == 14), 5'd0, 1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_OUTPUT, 8'h00, 1'b0, 5'd9, 1'b0, '0});
        for (i = 0; i < 16; i++)
            rows.push_back('{ackdf_pkg::FUNC_ABSORB, 8'(~i), (i == 15), 5'd0, 1'b0, '0});
        rows.push_back('{ackdf_pkg::FUNC_OUTPUT, 8'h00, 1'b0, 5'd15, 1'b0, '0});
        for (i = 0; i < rows.size(); i++)
        begin
            r = rows[i];
            push_item(r.fn, r.info, r.last, r.nbytes, r.has_fixed, r.fixed);
        end

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(ackdf_pkg::REG_KEY_WORD_0, '1);
                    write_reg(ackdf_pkg::REG_KEY_WORD_1, '1);
                end
                1:
                begin
                    write_reg(ackdf_pkg::REG_KEY_SIZE, 64'(ackdf_pkg::KEY_192));
                    write_reg(ackdf_pkg::REG_KEY_WORD_2, '1);
                end
                2:
                begin
                    write_reg(ackdf_pkg::REG_KEY_SIZE, 64'(ackdf_pkg::KEY_256));
                    write_reg(ackdf_pkg::REG_KEY_WORD_3, '1);
                end
                3:
                begin
                    write_reg(ackdf_pkg::REG_KEY_SIZE, 64'd3);
                    write_reg(ackdf_pkg::REG_KEY_SIZE + 3'd1, '1);
                end
                default:
                begin
                    for (i = 0; i < 4; i++)
                        write_reg(i[2:0], {$urandom, $urandom});
                    write_reg(ackdf_pkg::REG_KEY_SIZE, {$urandom, $urandom});
                end
            endcase
            if (p == 2)
            begin
                // stall the output side long enough to back the core up
                fork
                    begin
                        holdoff = 1'b1;
                        repeat (600) @(negedge clk);
                        holdoff = 1'b0;
                    end
                join_none
            end
            calm = (p == 1);
            random_run(230);
        end
        calm = 1'b0;
        write_reg(ackdf_pkg::REG_KEY_SIZE, 64'(ackdf_pkg::KEY_128));
        random_run(60);
        s_tvalid <= 1'b0;

        i = 0;
        while (expected_blocks.size() != 0 && i < 200000)
        begin
            @(negedge clk);
            i++;
        end
        repeat (40) @(negedge clk);
        if (errors == 0 && expected_blocks.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
